// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
// No dependencies; imported by tcw_ctrl, tcw_datapath and the top level.
package tcw_pkg;

  // Fixed field widths of the request and result channels
  localparam int OP_W      = 3;
  localparam int CHAR_W    = 8;
  localparam int COLUMN_W  = 7;
  localparam int ROW_IN_W  = 5;
  localparam int COLOR_W   = 4;
  localparam int ADDR_IN_W = 11;
  localparam int CURSOR_W  = 11;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
  localparam logic [OP_W-1:0] OP_COLOR = 3'd2;
  localparam logic [OP_W-1:0] OP_POS   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // Controller to datapath
  typedef struct packed {
    logic latch_req;
    logic set_color;
    logic load_pos;
    logic char_exec;
    logic clear_cursor;
    logic cnt_clr;
    logic cnt_inc;
    logic scroll_step;
    logic scroll_cursor;
    logic fill_step;
    logic read_issue;
    logic out_load;
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_bad;
    logic            addr_bad;
    logic            at_end;
    logic            copy_end;
    logic            fill_end;
    logic            out_free;
  } tcw_sts_t;

endpackage

// ===== sv/tcw_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tcw_ctrl.sv =====
// Sequencing state machine for the text console character writer.
// Depends on tcw_pkg (command and status structs, opcodes).
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;  // clearing pass after reset
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_CHAR   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_BLANK  = 3'd5;  // blank bottom row after scroll
  localparam logic [2:0] S_CLEAR  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_INIT: begin
        cmd.fill_step = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.fill_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_PUT: state_next = S_CHAR;
          OP_CLEAR: begin
            cmd.clear_cursor = 1'b1;
            cmd.cnt_clr      = 1'b1;
            state_next       = S_CLEAR;
          end
          OP_COLOR: begin
            cmd.set_color = 1'b1;
            state_next    = S_DONE;
          end
          OP_POS: begin
            if (!sts.pos_bad) begin
              cmd.load_pos = 1'b1;
              state_next   = S_CHAR;
            end else begin
              state_next = S_DONE;
            end
          end
          OP_READ: begin
            cmd.read_issue = !sts.addr_bad;
            state_next     = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CHAR: begin
        if (sts.at_end) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_SCROLL;
        end else begin
          cmd.char_exec = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.copy_end) begin
          cmd.scroll_cursor = 1'b1;
          state_next        = S_BLANK;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_BLANK: begin
        cmd.fill_step = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.fill_end) state_next = S_CHAR;
      end
      S_CLEAR: begin
        cmd.fill_step = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.fill_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/tcw_datapath.sv =====
// Datapath: request latch, cursor, colour, sweep counter, cell RAM, result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tcw_pkg::tcw_cmd_t                 cmd,
  output tcw_pkg::tcw_sts_t                 sts,
  input  logic [tcw_pkg::OP_W-1:0]          opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
  input  logic [tcw_pkg::COLUMN_W-1:0]      column,
  input  logic [tcw_pkg::ROW_IN_W-1:0]      row,
  input  logic [tcw_pkg::COLOR_W-1:0]       foreground,
  input  logic [tcw_pkg::COLOR_W-1:0]       background,
  input  logic [tcw_pkg::ADDR_IN_W-1:0]     cell_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tcw_pkg::CURSOR_W-1:0]      cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]        cell_value,
  output logic                              status
);
  import tcw_pkg::*;

  localparam int TOTAL  = COLS * ROWS;
  localparam int IDX_W  = $clog2(TOTAL + 1);
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int COL_W  = $clog2(COLS);

  localparam logic [IDX_W-1:0] TOTAL_I   = IDX_W'(TOTAL);
  localparam logic [IDX_W-1:0] COLS_I    = IDX_W'(COLS);
  localparam logic [IDX_W-1:0] COPY_LAST = IDX_W'(TOTAL - COLS);
  localparam logic [IDX_W-1:0] FILL_LAST = IDX_W'(TOTAL - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLS - 1);

  // latched request
  logic [OP_W-1:0]      op_q;
  logic [CHAR_W-1:0]    ch_q;
  logic [COLUMN_W-1:0]  col_q;
  logic [ROW_IN_W-1:0]  row_q;
  logic [COLOR_W-1:0]   fg_q;
  logic [COLOR_W-1:0]   bg_q;
  logic [ADDR_IN_W-1:0] addr_q;

  // cursor kept as row start plus column
  logic [IDX_W-1:0]  row_base;
  logic [COL_W-1:0]  col_pos;
  logic [ATTR_W-1:0] color;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  cursor;
  logic [IDX_W-1:0]  cursor_m1;
  logic              is_nl;
  logic              is_bs;
  logic              pos_bad;
  logic              addr_bad;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  assign cursor    = row_base + IDX_W'(col_pos);
  assign cursor_m1 = cursor - IDX_W'(1);
  assign is_nl     = (ch_q == CH_NEWLINE) || (ch_q == CH_RETURN);
  assign is_bs     = (ch_q == CH_BACKSPACE);
  assign pos_bad   = (32'(col_q) >= COLS) || (32'(row_q) >= ROWS);
  assign addr_bad  = (32'(addr_q) >= TOTAL);

  assign sts.op       = op_q;
  assign sts.pos_bad  = pos_bad;
  assign sts.addr_bad = addr_bad;
  assign sts.at_end   = (cursor >= TOTAL_I);
  assign sts.copy_end = (cnt == COPY_LAST);
  assign sts.fill_end = (cnt == FILL_LAST);
  assign sts.out_free = !out_valid || out_ready;

  // RAM port selection; commands never overlap
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    if (cmd.fill_step) begin
      we    = 1'b1;
      waddr = cnt[ADDR_W-1:0];
      wdata = {color, CH_SPACE};
    end
    if (cmd.scroll_step) begin
      // read one row below, write back what was read last cycle
      if (cnt != COPY_LAST) begin
        re    = 1'b1;
        raddr = ADDR_W'(cnt + COLS_I);
      end
      if (cnt != '0) begin
        we    = 1'b1;
        waddr = ADDR_W'(cnt - IDX_W'(1));
        wdata = rdata;
      end
    end
    if (cmd.char_exec) begin
      if (is_bs) begin
        if (cursor != '0) begin
          we    = 1'b1;
          waddr = cursor_m1[ADDR_W-1:0];
          wdata = {color, CH_SPACE};
        end
      end else if (!is_nl) begin
        we    = 1'b1;
        waddr = cursor[ADDR_W-1:0];
        wdata = {color, ch_q};
      end
    end
    if (cmd.read_issue) begin
      re    = 1'b1;
      raddr = ADDR_W'(addr_q);
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TOTAL)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      op_q   <= opcode;
      ch_q   <= char_code;
      col_q  <= column;
      row_q  <= row;
      fg_q   <= foreground;
      bg_q   <= background;
      addr_q <= cell_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color    <= '0;
      row_base <= '0;
      col_pos  <= '0;
      cnt      <= '0;
    end else begin
      if (cmd.set_color || cmd.load_pos) color <= {bg_q, fg_q};

      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + IDX_W'(1);
      end

      if (cmd.clear_cursor) begin
        row_base <= '0;
        col_pos  <= '0;
      end else if (cmd.load_pos) begin
        row_base <= IDX_W'(row_q * COLS);
        col_pos  <= COL_W'(col_q);
      end else if (cmd.scroll_cursor) begin
        row_base <= row_base - COLS_I;
      end else if (cmd.char_exec) begin
        if (is_nl) begin
          row_base <= row_base + COLS_I;
          col_pos  <= '0;
        end else if (is_bs) begin
          if (cursor != '0) begin
            if (col_pos == '0) begin
              col_pos  <= COL_LAST;
              row_base <= row_base - COLS_I;
            end else begin
              col_pos <= col_pos - COL_W'(1);
            end
          end
        end else if (col_pos == COL_LAST) begin
          col_pos  <= '0;
          row_base <= row_base + COLS_I;
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_position <= CURSOR_W'(cursor);
      cell_value      <= (op_q == OP_READ && !addr_bad) ? rdata : '0;
      status          <= ((op_q == OP_POS) && pos_bad) || ((op_q == OP_READ) && addr_bad);
    end
  end

endmodule

// ===== sv/text_console_char_writer.sv =====
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath (which holds tcw_ram).
//
// Usage
//   Request channel (in_valid/in_ready) carries opcode, char_code, column,
//   row, foreground, background and cell_address. Every request gives
//   exactly one result on the out_valid/out_ready channel: cursor_position,
//   cell_value and status.
//   Requests are handled one at a time; in_ready is high only while the
//   controller is idle, so a new request is taken only after the last one
//   has loaded its result. Set colour, read cell, an unused opcode and a
//   rejected position go straight to the result; put char and put at
//   position without scroll execute the character directly. A put char that
//   scrolls first moves every row up, one cell moved per cycle through the
//   single read and write port of the cell RAM, then blanks the bottom row.
//   Clear blanks every cell, one cell per cycle. After reset the controller
//   sweeps the cell RAM, writing a blank space to every cell, with in_ready
//   low throughout. The result sits in an output register; if the receiver
//   stalls, the block finishes the current request and then holds it until
//   the register frees up. A result still waiting does not stop the next
//   request from being accepted.
module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::OP_W-1:0]      opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::COLUMN_W-1:0]  column,
  input  logic [tcw_pkg::ROW_IN_W-1:0]  row,
  input  logic [tcw_pkg::COLOR_W-1:0]   foreground,
  input  logic [tcw_pkg::COLOR_W-1:0]   background,
  input  logic [tcw_pkg::ADDR_IN_W-1:0] cell_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::CURSOR_W-1:0]  cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value,
  output logic                          status
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  // controller: sequences each request, sweeps for scroll and clear
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: cursor, colour, cell RAM and the result register
  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .opcode          (opcode),
    .char_code       (char_code),
    .column          (column),
    .row             (row),
    .foreground      (foreground),
    .background      (background),
    .cell_address    (cell_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .cell_value      (cell_value),
    .status          (status)
  );

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while previous one still waiting");

  // a character is never written with the cursor past the last cell
  a_char_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.char_exec |-> !sts.at_end)
    else $error("character executed with cursor past the end");

  // an out-of-range position never moves the cursor
  a_pos_checked: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pos |-> !sts.pos_bad)
    else $error("cursor loaded from an out-of-range position");

  // in_ready is low as reset falls, when the post-reset clearing sweep starts
  a_init_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !in_ready)
    else $error("request accepted before the clearing sweep");

endmodule
